// ===== sv/bss_pkg.sv =====
package bss_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int ELEM_WIDTH_DEF = 32;

	localparam int MODE_W     = 2;
	localparam int ELEM_PORT_W = 32;
	localparam int COUNT_W    = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic scan;
		logic shift;
		logic insert;
		logic refuse;
		logic found;
		logic drop;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              hit;
		logic              sweep_end;
		logic              full;
	} sts_t;

endpackage

// ===== sv/bss_ctrl.sv =====
module bss_ctrl
	import bss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.mode == MODE_NONE) begin
					state_d = ST_FINISH;
				end else if (sts.hit) begin
					if (sts.mode == MODE_REMOVE) begin
						cmd.found = 1'b1;
						state_d   = ST_SHIFT;
					end else begin
						// duplicate insert leaves the store alone
						cmd.found = (sts.mode == MODE_LOOKUP);
						state_d   = ST_FINISH;
					end
				end else if (sts.sweep_end) begin
					if (sts.mode == MODE_INSERT) begin
						cmd.insert = !sts.full;
						cmd.refuse = sts.full;
					end
					state_d = ST_FINISH;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.sweep_end) begin
					cmd.drop = 1'b1;
					state_d  = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/bss_datapath.sv =====
module bss_datapath
	import bss_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [MODE_W-1:0]      mode,
	input  logic [ELEM_PORT_W-1:0] element,
	output logic                   success,
	output logic                   refused_full,
	output logic [COUNT_W-1:0]     count,
	output logic                   is_empty
);

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [ELEM_WIDTH-1:0] mem [CAPACITY];

	logic [MODE_W-1:0]     mode_q;
	logic [ELEM_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]      held_q;
	logic [CNT_W-1:0]      ptr_q;
	logic                  ok_q;
	logic                  refused_q;

	logic                  vld_s1;
	logic [ADDR_W-1:0]     idx_s1;
	logic [ELEM_WIDTH-1:0] rd_s1;

	logic                  success_q;
	logic                  refused_full_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  is_empty_q;

	logic hit_now;
	logic issue;
	logic more;

	assign more    = (ptr_q < held_q);
	assign hit_now = cmd.scan && vld_s1 && (rd_s1 == value_q);
	assign issue   = ((cmd.scan && !hit_now) || cmd.shift) && more;

	assign sts.mode      = mode_q;
	assign sts.hit       = hit_now;
	assign sts.sweep_end = !vld_s1 && !more;
	assign sts.full      = (held_q == CAP_CNT);

	// store: one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.insert)
			mem[held_q[ADDR_W-1:0]] <= value_q;
		else if (cmd.shift && vld_s1)
			mem[idx_s1 - ADDR_W'(1)] <= rd_s1;
		rd_s1  <= mem[ptr_q[ADDR_W-1:0]];
		idx_s1 <= ptr_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			held_q    <= '0;
			ptr_q     <= '0;
			ok_q      <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.take) begin
				ptr_q     <= '0;
				ok_q      <= 1'b0;
				refused_q <= 1'b0;
			end else if (hit_now) begin
				// restart the sweep just past the match to close the gap
				ptr_q <= CNT_W'(idx_s1) + CNT_W'(1);
			end else if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.insert) begin
				held_q <= held_q + CNT_W'(1);
				ok_q   <= 1'b1;
			end else if (cmd.drop) begin
				held_q <= held_q - CNT_W'(1);
			end
			if (cmd.found)
				ok_q <= 1'b1;
			if (cmd.refuse)
				refused_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q  <= mode;
			value_q <= ELEM_WIDTH'(element);
		end
		if (cmd.emit) begin
			success_q      <= ok_q;
			refused_full_q <= refused_q;
			count_q        <= COUNT_W'(held_q);
			is_empty_q     <= (held_q == '0);
		end
	end

	assign success      = success_q;
	assign refused_full = refused_full_q;
	assign count        = count_q;
	assign is_empty     = is_empty_q;

endmodule

// ===== sv/bounded_set_store_top.sv =====
// out_valid rises after a sweep over the held entries for lookup, insert and a missed remove
// (a hit ends the scan early); a remove that hits also shifts the later entries down.
// One word is in work at a time: a new word is taken only once the last result is emitted,
// limited by the sequential sweep over the store, one entry read per cycle.
// Reset (arst_n low, asynchronous) empties the set and drops any pending result;
// store contents are left as they were and are rewritten before use.
module bounded_set_store_top
	import bss_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [MODE_W-1:0]      mode,
	input  logic [ELEM_PORT_W-1:0] element,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   success,
	output logic                   refused_full,
	output logic [COUNT_W-1:0]     count,
	output logic                   is_empty
);

	cmd_t cmd;
	sts_t sts;

	bss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bss_datapath #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.element      (element),
		.success      (success),
		.refused_full (refused_full),
		.count        (count),
		.is_empty     (is_empty)
	);

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.insert, cmd.refuse, cmd.drop, cmd.emit}))
		else $error("conflicting datapath commands");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("new word taken while one is in work");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.insert && sts.full))
		else $error("insert into full store");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("result raised without emit");

endmodule

// ===== tb/bounded_set_store_top_tb.sv =====
module bounded_set_store_top_tb;
	import bss_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int POOL_SIZE  = 24;

	typedef struct {
		logic [MODE_W-1:0]      mode;
		logic [ELEM_PORT_W-1:0] element;
		bit                     drain;
	} set_op_t;

	typedef struct packed {
		logic               success;
		logic               refused_full;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} set_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [MODE_W-1:0]      mode = MODE_INSERT;
	logic [ELEM_PORT_W-1:0] element = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   success;
	logic                   refused_full;
	logic [COUNT_W-1:0]     count;
	logic                   is_empty;

	set_op_t                pending_ops[$];
	set_result_t            expected_results[$];
	logic [ELEM_PORT_W-1:0] held_values[$];
	set_result_t            got_result;
	set_result_t            want_result;
	int                     n_total;
	int                     n_sent;
	int                     n_errors;
	int                     idle_cycles;

	bounded_set_store_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.element      (element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.success      (success),
		.refused_full (refused_full),
		.count        (count),
		.is_empty     (is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the shadow set and return the result it should produce.
	function automatic set_result_t apply_set_op(input logic [MODE_W-1:0] op,
			input logic [ELEM_PORT_W-1:0] val);
		set_result_t r;
		int          slot;
		r = '0;
		slot = -1;
		foreach (held_values[i])
			if (slot < 0 && held_values[i] == val)
				slot = i;
		case (op)
			MODE_INSERT: begin
				if (slot < 0) begin
					if (held_values.size() >= CAPACITY_DEF)
						r.refused_full = 1'b1;
					else begin
						held_values.push_back(val);
						r.success = 1'b1;
					end
				end
			end
			MODE_REMOVE: begin
				if (slot >= 0) begin
					held_values.delete(slot);
					r.success = 1'b1;
				end
			end
			MODE_LOOKUP: r.success = (slot >= 0);
			default: ;
		endcase
		r.count = COUNT_W'(held_values.size());
		r.is_empty = (held_values.size() == 0);
		return r;
	endfunction

	function automatic int send_idle_pct();
		if (n_sent < n_total / 3)
			return 13;
		if (n_sent < 2 * n_total / 3)
			return 54;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (n_sent < n_total / 3)
			return 54;
		if (n_sent < 2 * n_total / 3)
			return 13;
		return 0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		n_errors++;
		$display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	task automatic add_op(input logic [MODE_W-1:0] op, input logic [ELEM_PORT_W-1:0] val,
			input bit drain);
		set_op_t w;
		w.mode = op;
		w.element = val;
		w.drain = drain;
		pending_ops.push_back(w);
	endtask

	// Driver: a word that waits for drain holds back until all results are in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_set_op(mode, element));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() != 0
						&& !(pending_ops[0].drain && expected_results.size() != 0)
						&& $urandom_range(0, 99) >= send_idle_pct()) begin
					in_valid <= 1'b1;
					mode <= pending_ops[0].mode;
					element <= pending_ops[0].element;
					pending_ops.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result word with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_result = '{success, refused_full, count, is_empty};
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 32'd0, 32'(got_result));
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.success !== want_result.success)
						report_mismatch("success", 32'(want_result.success),
							32'(got_result.success));
					if (got_result.refused_full !== want_result.refused_full)
						report_mismatch("refused_full", 32'(want_result.refused_full),
							32'(got_result.refused_full));
					if (got_result.count !== want_result.count)
						report_mismatch("count", 32'(want_result.count),
							32'(got_result.count));
					if (got_result.is_empty !== want_result.is_empty)
						report_mismatch("is_empty", 32'(want_result.is_empty),
							32'(got_result.is_empty));
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [ELEM_PORT_W-1:0] pool[POOL_SIZE];
		logic [MODE_W-1:0]      op;
		logic [ELEM_PORT_W-1:0] val;
		int                     bias;
		int                     seg_len;
		int                     r;
		int                     n_rand;

		n_sent = 0;
		n_errors = 0;
		idle_cycles = 0;

		// Directed: extremes, duplicates, misses, unused mode, fill to full, refusal.
		add_op(MODE_INSERT, 32'h0000_0000, 1'b0);
		add_op(MODE_INSERT, 32'hFFFF_FFFF, 1'b0);
		add_op(MODE_INSERT, 32'h0000_0000, 1'b0);
		add_op(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b0);
		add_op(MODE_LOOKUP, 32'h0000_0001, 1'b0);
		add_op(MODE_REMOVE, 32'h0000_0002, 1'b0);
		add_op(MODE_NONE,   32'h5A5A_A5A5, 1'b0);
		add_op(MODE_REMOVE, 32'h0000_0000, 1'b0);
		for (int i = 0; i < CAPACITY_DEF - 1; i++)
			add_op(MODE_INSERT, 32'hA500_0100 + i, 1'b0);
		add_op(MODE_INSERT, 32'h1234_5678, 1'b0);
		add_op(MODE_REMOVE, 32'hA500_0107, 1'b0);
		add_op(MODE_LOOKUP, 32'hA500_010E, 1'b0);

		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			pool[i] = $urandom;

		// Random: segments biased toward filling, draining or mixing the set.
		n_rand = 0;
		while (n_rand < 1625) begin
			bias = $urandom_range(0, 2);
			seg_len = $urandom_range(20, 60);
			for (int k = 0; k < seg_len && n_rand < 1625; k++) begin
				r = $urandom_range(0, 99);
				case (bias)
					0: op = (r < 70) ? MODE_INSERT : (r < 80) ? MODE_REMOVE :
						(r < 97) ? MODE_LOOKUP : MODE_NONE;
					1: op = (r < 15) ? MODE_INSERT : (r < 80) ? MODE_REMOVE :
						(r < 97) ? MODE_LOOKUP : MODE_NONE;
					default: op = (r < 35) ? MODE_INSERT : (r < 70) ? MODE_REMOVE :
						(r < 97) ? MODE_LOOKUP : MODE_NONE;
				endcase
				val = ($urandom_range(0, 99) < 6) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
				add_op(op, val, (n_rand == 0) || (n_rand == 800) || ($urandom_range(0, 199) == 0));
				n_rand++;
			end
		end
		n_total = pending_ops.size();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY_DEF + 10) @(posedge clk);

		foreach (expected_results[i])
			report_mismatch("missing result", 32'(expected_results[i]), 32'd0);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== bounded_set_store_top.f =====
sv/bss_pkg.sv
sv/bss_ctrl.sv
sv/bss_datapath.sv
sv/bounded_set_store_top.sv
tb/bounded_set_store_top_tb.sv
